### rtl/dwpi_pkg.sv
// ----------------------------------------------------------------------------
// dwpi_pkg
// Shared types and constants of the dual wheel PI controller: register
// indexes, register width and the configuration bundle.
// ----------------------------------------------------------------------------
package dwpi_pkg;

	localparam int REG_WIDTH       = 15;
	localparam int CFG_INDEX_WIDTH = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ERROR_GAIN      = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PREV_ERROR_GAIN = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANT_POLE      = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLANT_GAIN      = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPEED_LIMIT     = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_VOLTAGE_LIMIT   = 3'd5;

	localparam logic [REG_WIDTH-1:0] RST_ERROR_GAIN      = 15'd5106;
	localparam logic [REG_WIDTH-1:0] RST_PREV_ERROR_GAIN = 15'd1799;
	localparam logic [REG_WIDTH-1:0] RST_PLANT_POLE      = 15'd9252;
	localparam logic [REG_WIDTH-1:0] RST_PLANT_GAIN      = 15'd22725;
	localparam logic [REG_WIDTH-1:0] RST_SPEED_LIMIT     = 15'd8581;
	localparam logic [REG_WIDTH-1:0] RST_VOLTAGE_LIMIT   = 15'd3072;

	typedef struct packed {
		logic [REG_WIDTH-1:0] error_gain;
		logic [REG_WIDTH-1:0] prev_error_gain;
		logic [REG_WIDTH-1:0] plant_pole;
		logic [REG_WIDTH-1:0] plant_gain;
		logic [REG_WIDTH-1:0] speed_limit;
		logic [REG_WIDTH-1:0] voltage_limit;
	} dwpi_cfg_t;

endpackage

### rtl/dwpi_cfg.sv
// ----------------------------------------------------------------------------
// dwpi_cfg
// Configuration register file: gains, model coefficients and limits,
// written one register per transfer.
// ----------------------------------------------------------------------------
module dwpi_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dwpi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [dwpi_pkg::REG_WIDTH-1:0]       cfg_data,
	output dwpi_pkg::dwpi_cfg_t                  cfg
);
	import dwpi_pkg::*;

	dwpi_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.error_gain      <= RST_ERROR_GAIN;
			cfg_q.prev_error_gain <= RST_PREV_ERROR_GAIN;
			cfg_q.plant_pole      <= RST_PLANT_POLE;
			cfg_q.plant_gain      <= RST_PLANT_GAIN;
			cfg_q.speed_limit     <= RST_SPEED_LIMIT;
			cfg_q.voltage_limit   <= RST_VOLTAGE_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ERROR_GAIN:      cfg_q.error_gain      <= cfg_data;
				REG_PREV_ERROR_GAIN: cfg_q.prev_error_gain <= cfg_data;
				REG_PLANT_POLE:      cfg_q.plant_pole      <= cfg_data;
				REG_PLANT_GAIN:      cfg_q.plant_gain      <= cfg_data;
				REG_SPEED_LIMIT:     cfg_q.speed_limit     <= cfg_data;
				REG_VOLTAGE_LIMIT:   cfg_q.voltage_limit   <= cfg_data;
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

endmodule

### rtl/dwpi_wheel.sv
// ----------------------------------------------------------------------------
// dwpi_wheel
// One wheel: reference clamp, incremental PI drive update and first-order
// motor model, with the per-wheel state registers that also serve as the
// result registers.
// ----------------------------------------------------------------------------
module dwpi_wheel #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dwpi_pkg::dwpi_cfg_t            cfg,
	input  logic                           en,
	input  logic signed [SAMPLE_WIDTH-1:0] ref_speed,
	input  logic signed [SAMPLE_WIDTH-1:0] meas_speed,
	output logic signed [SAMPLE_WIDTH-1:0] drive,
	output logic signed [SAMPLE_WIDTH-1:0] model
);
	import dwpi_pkg::*;

	localparam int PW = SAMPLE_WIDTH + 19;
	localparam int MW = SAMPLE_WIDTH + 17;
	localparam logic signed [PW-1:0] RND  = {{(PW-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS-1);
	localparam logic signed [PW-1:0] SMAX =
		{{(PW-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [PW-1:0] SMIN = ~SMAX;

	logic signed [SAMPLE_WIDTH:0]   last_err_q;
	logic signed [SAMPLE_WIDTH-1:0] last_drive_q;
	logic signed [SAMPLE_WIDTH-1:0] last_model_q;

	logic signed [SAMPLE_WIDTH-1:0] ref_clamped;
	logic signed [SAMPLE_WIDTH:0]   err;
	logic signed [MW-1:0]           p_err;
	logic signed [MW-1:0]           p_last_err;
	logic signed [MW-1:0]           p_model;
	logic signed [MW-1:0]           p_drive;
	logic signed [PW-1:0]           drv_sum;
	logic signed [PW-1:0]           mdl_sum;
	logic signed [PW-1:0]           drv_full;
	logic signed [PW-1:0]           mdl_full;
	logic signed [SAMPLE_WIDTH-1:0] drive_next;
	logic signed [SAMPLE_WIDTH-1:0] model_next;

	function automatic logic signed [PW-1:0] sat_clamp(
		input logic signed [PW-1:0] v,
		input logic [REG_WIDTH-1:0] lim
	);
		logic signed [PW-1:0] s;
		logic signed [PW-1:0] l;
		s = v;
		l = $signed({{(PW-REG_WIDTH){1'b0}}, lim});
		if (s > SMAX)
			s = SMAX;
		else if (s < SMIN)
			s = SMIN;
		if (s > l)
			s = l;
		else if (s < -l)
			s = -l;
		return s;
	endfunction

	always_comb begin
		ref_clamped = SAMPLE_WIDTH'(sat_clamp(PW'(ref_speed), cfg.speed_limit));
		err         = (SAMPLE_WIDTH+1)'(ref_clamped) - (SAMPLE_WIDTH+1)'(meas_speed);

		p_err      = MW'($signed({1'b0, cfg.error_gain})) * MW'(err);
		p_last_err = MW'($signed({1'b0, cfg.prev_error_gain})) * MW'(last_err_q);
		p_model    = MW'($signed({1'b0, cfg.plant_pole})) * MW'(last_model_q);
		p_drive    = MW'($signed({1'b0, cfg.plant_gain})) * MW'(last_drive_q);

		drv_sum  = PW'(p_err) - PW'(p_last_err) + RND;
		drv_full = (drv_sum >>> COEF_FRAC_BITS) + PW'(last_drive_q);
		mdl_sum  = PW'(p_model) + PW'(p_drive) + RND;
		mdl_full = mdl_sum >>> COEF_FRAC_BITS;

		drive_next = SAMPLE_WIDTH'(sat_clamp(drv_full, cfg.voltage_limit));
		model_next = SAMPLE_WIDTH'(sat_clamp(mdl_full, cfg.speed_limit));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q   <= '0;
			last_drive_q <= '0;
			last_model_q <= '0;
		end else if (en) begin
			last_err_q   <= err;
			last_drive_q <= drive_next;
			last_model_q <= model_next;
		end
	end

	assign drive = last_drive_q;
	assign model = last_model_q;

endmodule

### rtl/dual_wheel_pi_with_plant_model.sv
// ----------------------------------------------------------------------------
// dual_wheel_pi_with_plant_model
// Dual wheel incremental PI speed controller with a first-order motor model.
//
// One input transfer carries the speed references and measured speeds of
// both wheels for one control tick; one output transfer returns the clamped
// drive voltages and model speeds of that tick. Input transfers use
// in_valid/in_stall, output transfers out_valid/out_stall.
// An item waits in the input register and is then computed in a single pass
// into the result registers, one item per cycle while the receiver does not
// stall, set by the single pass through the four multipliers of each wheel.
// The result registers double as the controller state. When the receiver
// stalls the result holds, one further item waits in the input register,
// and then in_stall rises. Reset clears the controller state to zero,
// restores the register reset values and empties both registers. Registers
// are written through cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// the user must write them between ticks only, the block does not enforce it.
// ----------------------------------------------------------------------------
module dual_wheel_pi_with_plant_model #(
	parameter int SAMPLE_WIDTH   = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]       ref_right,
	input  logic signed [SAMPLE_WIDTH-1:0]       ref_left,
	input  logic signed [SAMPLE_WIDTH-1:0]       measured_right,
	input  logic signed [SAMPLE_WIDTH-1:0]       measured_left,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]       drive_right,
	output logic signed [SAMPLE_WIDTH-1:0]       drive_left,
	output logic signed [SAMPLE_WIDTH-1:0]       model_speed_right,
	output logic signed [SAMPLE_WIDTH-1:0]       model_speed_left,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dwpi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [dwpi_pkg::REG_WIDTH-1:0]       cfg_data
);
	import dwpi_pkg::*;

	localparam int CMPW = SAMPLE_WIDTH + REG_WIDTH + 2;

	dwpi_cfg_t cfg;

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] ref_right_s1;
	logic signed [SAMPLE_WIDTH-1:0] ref_left_s1;
	logic signed [SAMPLE_WIDTH-1:0] meas_right_s1;
	logic signed [SAMPLE_WIDTH-1:0] meas_left_s1;
	logic                           out_valid_q;
	logic                           in_take;
	logic                           advance;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	dwpi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ref_right_s1  <= ref_right;
			ref_left_s1   <= ref_left;
			meas_right_s1 <= measured_right;
			meas_left_s1  <= measured_left;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	dwpi_wheel #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_wheel_right (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.en         (advance),
		.ref_speed  (ref_right_s1),
		.meas_speed (meas_right_s1),
		.drive      (drive_right),
		.model      (model_speed_right)
	);

	dwpi_wheel #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_wheel_left (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.en         (advance),
		.ref_speed  (ref_left_s1),
		.meas_speed (meas_left_s1),
		.drive      (drive_left),
		.model      (model_speed_left)
	);

	// checks
	logic signed [CMPW-1:0] chk_drive_r;
	logic signed [CMPW-1:0] chk_model_l;
	logic signed [CMPW-1:0] chk_vlim;
	logic signed [CMPW-1:0] chk_slim;

	assign chk_drive_r = CMPW'(drive_right);
	assign chk_model_l = CMPW'(model_speed_left);
	assign chk_vlim    = $signed({{(CMPW-REG_WIDTH){1'b0}}, cfg.voltage_limit});
	assign chk_slim    = $signed({{(CMPW-REG_WIDTH){1'b0}}, cfg.speed_limit});

	a_drive_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (chk_drive_r <= chk_vlim) && (chk_drive_r >= -chk_vlim))
		else $error("drive outside voltage limit");

	a_model_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (chk_model_l <= chk_slim) && (chk_model_l >= -chk_slim))
		else $error("model speed outside speed limit");

	a_held_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && out_stall |=> valid_s1 && out_valid_q)
		else $error("item dropped while output stalled");

endmodule

### tb/dwpi_checker.sv
// ----------------------------------------------------------------------------
// dwpi_checker
// Watches the tick, result and register channels of the dual wheel PI
// controller. Each accepted tick is run through a cycle-free model of both
// wheels (reference clamp, incremental PI drive, first-order motor model,
// saturation and clamps). The predicted result is queued and compared field
// by field with the next result transfer. The model follows register writes
// and hands the mismatch count and the number of outstanding results to the
// testbench top.
// ----------------------------------------------------------------------------
module dwpi_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [15:0]                   ref_right,
	input  logic signed [15:0]                   ref_left,
	input  logic signed [15:0]                   measured_right,
	input  logic signed [15:0]                   measured_left,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [15:0]                   drive_right,
	input  logic signed [15:0]                   drive_left,
	input  logic signed [15:0]                   model_speed_right,
	input  logic signed [15:0]                   model_speed_left,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [dwpi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [dwpi_pkg::REG_WIDTH-1:0]       cfg_data,
	output int                                   mismatches,
	output int                                   pending
);
	import dwpi_pkg::*;

	localparam int SW   = 16;
	localparam int FRAC = 14;

	typedef logic signed [SW-1:0] sample_t;

	typedef struct packed {
		logic signed [SW-1:0] drive_r;
		logic signed [SW-1:0] drive_l;
		logic signed [SW-1:0] model_r;
		logic signed [SW-1:0] model_l;
	} wheel_result_t;

	wheel_result_t expected_results[$];

	longint k_err, k_prev_err, k_pole, k_plant, speed_lim, volt_lim;

	// per wheel controller state, index 0 right, 1 left
	logic signed [SW:0] last_err [2];
	sample_t            last_drive [2];
	sample_t            last_model [2];

	int bad;

	function automatic longint round_q14(input longint v);
		return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic longint sat_sample(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic longint clamp_sym(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic void pi_wheel(input int w, input sample_t speed_ref,
			input sample_t speed_meas, output sample_t drive_o, output sample_t model_o);
		longint r, e, d, m;
		r = clamp_sym(longint'(speed_ref), speed_lim);
		e = r - longint'(speed_meas);
		d = round_q14(k_err * e - k_prev_err * longint'(last_err[w]))
			+ longint'(last_drive[w]);
		d = clamp_sym(sat_sample(d), volt_lim);
		m = round_q14(k_pole * longint'(last_model[w]) + k_plant * longint'(last_drive[w]));
		m = clamp_sym(sat_sample(m), speed_lim);
		last_err[w]   = e[SW:0];
		last_drive[w] = d[SW-1:0];
		last_model[w] = m[SW-1:0];
		drive_o = d[SW-1:0];
		model_o = m[SW-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		wheel_result_t want, got;
		if (!arst_n) begin
			k_err      = RST_ERROR_GAIN;
			k_prev_err = RST_PREV_ERROR_GAIN;
			k_pole     = RST_PLANT_POLE;
			k_plant    = RST_PLANT_GAIN;
			speed_lim  = RST_SPEED_LIMIT;
			volt_lim   = RST_VOLTAGE_LIMIT;
			for (int w = 0; w < 2; w++) begin
				last_err[w]   = '0;
				last_drive[w] = '0;
				last_model[w] = '0;
			end
			expected_results.delete();
			bad = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ERROR_GAIN:      k_err      = cfg_data;
					REG_PREV_ERROR_GAIN: k_prev_err = cfg_data;
					REG_PLANT_POLE:      k_pole     = cfg_data;
					REG_PLANT_GAIN:      k_plant    = cfg_data;
					REG_SPEED_LIMIT:     speed_lim  = cfg_data;
					REG_VOLTAGE_LIMIT:   volt_lim   = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				pi_wheel(0, ref_right, measured_right, want.drive_r, want.model_r);
				pi_wheel(1, ref_left, measured_left, want.drive_l, want.model_l);
				expected_results.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = {drive_right, drive_left, model_speed_right, model_speed_left};
				if (expected_results.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("unexpected result transfer: drive %0d/%0d model %0d/%0d",
							got.drive_r, got.drive_l, got.model_r, got.model_l);
				end else begin
					want = expected_results.pop_front();
					if (want !== got) begin
						bad++;
						if (bad <= 10) begin
							$display("result mismatch, expected: drive %0d %0d model %0d %0d",
								want.drive_r, want.drive_l, want.model_r, want.model_l);
							$display("result mismatch, actual:   drive %0d %0d model %0d %0d",
								got.drive_r, got.drive_l, got.model_r, got.model_l);
						end
					end
				end
			end
		end
		mismatches <= bad;
		pending    <= expected_results.size();
	end

endmodule

### tb/tb_dual_wheel_pi_with_plant_model.sv
// ----------------------------------------------------------------------------
// tb_dual_wheel_pi_with_plant_model
// Drives the dual wheel PI controller with a directed set of extreme ticks
// under boundary register settings, then random ticks in bursts over several
// random register settings while the result side stalls on its own pattern,
// once for a long stretch. Checking is left to dwpi_checker.
// ----------------------------------------------------------------------------
module tb_dual_wheel_pi_with_plant_model;
	import dwpi_pkg::*;

	localparam int SW          = 16;
	localparam int STALL_HOLD  = 300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_TICKS = 170;

	// indexes past the register map, writes there are dropped
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

	typedef logic signed [SW-1:0] sample_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	sample_t                    ref_right = '0;
	sample_t                    ref_left = '0;
	sample_t                    measured_right = '0;
	sample_t                    measured_left = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	sample_t                    drive_right;
	sample_t                    drive_left;
	sample_t                    model_speed_right;
	sample_t                    model_speed_left;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [REG_WIDTH-1:0]       cfg_data = '0;

	int mismatches;
	int pending;
	int cycles = 0;
	bit hold_req = 1'b0;

	logic [REG_WIDTH-1:0] reg_plan [6];

	initial begin
		forever #10 clk = ~clk;
	end

	dual_wheel_pi_with_plant_model dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.ref_right         (ref_right),
		.ref_left          (ref_left),
		.measured_right    (measured_right),
		.measured_left     (measured_left),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.drive_right       (drive_right),
		.drive_left        (drive_left),
		.model_speed_right (model_speed_right),
		.model_speed_left  (model_speed_left),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	dwpi_checker tick_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.ref_right         (ref_right),
		.ref_left          (ref_left),
		.measured_right    (measured_right),
		.measured_left     (measured_left),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.drive_right       (drive_right),
		.drive_left        (drive_left),
		.model_speed_right (model_speed_right),
		.model_speed_left  (model_speed_left),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.mismatches        (mismatches),
		.pending           (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side stall pattern, with a long hold-off on request
	initial begin : rx_pattern
		int mode, span, period;
		forever begin
			mode   = $urandom_range(0, 3);
			span   = $urandom_range(20, 200);
			period = $urandom_range(2, 7);
			for (int c = 0; c < span && !hold_req; c++) begin
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 2) == 0);
					2:       out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= (c % period == 0);
				endcase
				@(posedge clk);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (STALL_HOLD) @(posedge clk);
			end
		end
	end

	task automatic send_tick(input sample_t rr, input sample_t rl, input sample_t mr,
			input sample_t ml);
		ref_right      <= rr;
		ref_left       <= rl;
		measured_right <= mr;
		measured_left  <= ml;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input bit stray);
		if (stray) begin
			cfg_index <= ($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
			cfg_data  <= REG_WIDTH'($urandom);
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		for (int i = int'(REG_ERROR_GAIN); i <= int'(REG_VOLTAGE_LIMIT); i++) begin
			cfg_index <= CFG_INDEX_WIDTH'(i);
			cfg_data  <= reg_plan[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [REG_WIDTH-1:0] pick_reg(input int lo, input int hi);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			default: return REG_WIDTH'($urandom_range(lo, hi));
		endcase
	endfunction

	function automatic sample_t pick_sample(input int span);
		case ($urandom_range(0, 9))
			0:       return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
			1, 2:    return sample_t'($urandom);
			default: return sample_t'(int'($urandom_range(0, 2 * span)) - span);
		endcase
	endfunction

	// half the time measured speeds that track the reference, otherwise unrelated
	task automatic send_random(input int span);
		sample_t rr, rl, mr, ml;
		rr = pick_sample(span);
		rl = pick_sample(span);
		if ($urandom_range(0, 1) != 0) begin
			mr = sample_t'(int'(rr) + int'($urandom_range(0, 600)) - 300);
			ml = sample_t'(int'(rl) + int'($urandom_range(0, 600)) - 300);
		end else begin
			mr = pick_sample(span);
			ml = pick_sample(span);
		end
		send_tick(rr, rl, mr, ml);
	endtask

	initial begin : stimulus
		int n_sent, burst, span;
		bit gappy;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: reference clamp and both signs of the error
		send_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		send_tick(16'sh7fff, 16'sh8000, 16'sd0, 16'sd0);
		send_tick(16'sh8000, 16'sh7fff, 16'sd0, 16'sd0);
		send_tick(16'sd0, 16'sd0, 16'sh7fff, 16'sh8000);
		send_tick(16'sd0, 16'sd0, 16'sh8000, 16'sh7fff);
		send_tick(16'sd8581, -16'sd8581, 16'sd1, -16'sd1);
		go_idle();

		// widest error, full gains, no effective clamp: saturation
		for (int i = 0; i < 6; i++)
			reg_plan[i] = '1;
		load_config(1'b1);
		repeat (3) send_tick(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
		repeat (3) send_tick(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
		go_idle();

		// zero limits force everything to zero
		reg_plan[REG_ERROR_GAIN]      = 15'd16384;
		reg_plan[REG_PREV_ERROR_GAIN] = 15'd8192;
		reg_plan[REG_PLANT_POLE]      = 15'd8192;
		reg_plan[REG_PLANT_GAIN]      = 15'd16384;
		reg_plan[REG_SPEED_LIMIT]     = '0;
		reg_plan[REG_VOLTAGE_LIMIT]   = '0;
		load_config(1'b0);
		send_tick(16'sh7fff, 16'sh8000, 16'sd100, -16'sd100);
		send_tick(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send_tick(16'sd5, -16'sd5, 16'sd0, 16'sd0);
		go_idle();

		// zero gains
		reg_plan[REG_ERROR_GAIN]      = '0;
		reg_plan[REG_PREV_ERROR_GAIN] = '0;
		reg_plan[REG_PLANT_POLE]      = '0;
		reg_plan[REG_PLANT_GAIN]      = '0;
		reg_plan[REG_SPEED_LIMIT]     = '1;
		reg_plan[REG_VOLTAGE_LIMIT]   = '1;
		load_config(1'b1);
		send_tick(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
		send_tick(16'sd300, -16'sd300, 16'sd0, 16'sd0);
		send_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		go_idle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			reg_plan[REG_ERROR_GAIN]      = pick_reg(1000, 24000);
			reg_plan[REG_PREV_ERROR_GAIN] = pick_reg(0, 12000);
			reg_plan[REG_PLANT_POLE]      = pick_reg(2000, 16000);
			reg_plan[REG_PLANT_GAIN]      = pick_reg(4000, 28000);
			reg_plan[REG_SPEED_LIMIT]     = pick_reg(256, 12000);
			reg_plan[REG_VOLTAGE_LIMIT]   = pick_reg(256, 6000);
			load_config($urandom_range(0, 2) == 0);
			span = int'(reg_plan[REG_SPEED_LIMIT]) + 512;
			if (span > 32767)
				span = 32767;
			gappy = (ph % 3 != 2);
			if (ph == 1)
				hold_req = 1'b1;
			n_sent = 0;
			while (n_sent < PHASE_TICKS) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && n_sent < PHASE_TICKS; b++) begin
					send_random(span);
					n_sent++;
				end
				if (gappy && $urandom_range(0, 2) != 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(1, 10)) @(posedge clk);
				end
			end
			go_idle();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
